// File: src/ale_pkg.sv
// shared constants, character codes and line record types for the assembly line encoder
package ale_pkg;

    localparam int LINE_CHARS  = 16;
    localparam int CNT_W       = $clog2(LINE_CHARS + 1);
    localparam int IDX_W       = $clog2(LINE_CHARS);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // result status codes
    localparam logic [2:0] ST_ADDR    = 3'd0;
    localparam logic [2:0] ST_COMP    = 3'd1;
    localparam logic [2:0] ST_UNKNOWN = 3'd2;
    localparam logic [2:0] ST_SYMBOL  = 3'd3;
    localparam logic [2:0] ST_LONG    = 3'd4;

    // characters of interest
    localparam logic [7:0] CH_NL     = 8'd10;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_AT     = 8'h40;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    // one finished line as handed from the front end to the back end
    typedef struct packed {
        logic [LINE_CHARS-1:0][7:0] text;
        logic [CNT_W-1:0]           count;
        logic                       overflow;
        logic                       eq_found;
        logic [IDX_W-1:0]           eq_pos;
        logic                       semi_any_found;
        logic [IDX_W-1:0]           semi_any_pos;
        logic                       semi_eq_found;
        logic [IDX_W-1:0]           semi_eq_pos;
        logic                       second_digit;
        logic                       all_digits;
        logic [15:0]                addr_value;
    } line_t;

    // a mnemonic segment, right aligned, zero filled
    typedef struct packed {
        logic        too_long;
        logic [1:0]  len;
        logic [23:0] text;
    } seg_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] addr_value;
        seg_t        dest;
        seg_t        comp;
        seg_t        jump;
    } split_t;

endpackage

// File: src/ale_front.sv
// front end: takes characters, strips spaces and comments, gathers the line and its markers
module ale_front import ale_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       char_valid,
    input  logic [7:0] char_data,
    input  logic       queue_full,
    output logic       char_ready,
    output logic       line_push,
    output line_t      line_out
);

    logic [7:0]       text_reg [LINE_CHARS];
    logic [CNT_W-1:0] count_reg, count_next;
    logic             comment_reg, comment_next;
    logic             overflow_reg, overflow_next;
    logic             eq_found_reg, eq_found_next;
    logic [IDX_W-1:0] eq_pos_reg, eq_pos_next;
    logic             semi_any_found_reg, semi_any_found_next;
    logic [IDX_W-1:0] semi_any_pos_reg, semi_any_pos_next;
    logic             semi_eq_found_reg, semi_eq_found_next;
    logic [IDX_W-1:0] semi_eq_pos_reg, semi_eq_pos_next;
    logic             second_digit_reg, second_digit_next;
    logic             all_digits_reg, all_digits_next;
    logic [15:0]      value_reg, value_next;

    logic             accept;
    logic             keep;
    logic             is_digit;
    logic [3:0]       digit;
    logic [7:0]       digit_diff;
    logic [IDX_W-1:0] idx;

    assign char_ready = !queue_full;
    assign accept     = char_valid && char_ready;
    assign idx        = count_reg[IDX_W-1:0];
    assign is_digit   = (char_data >= CH_ZERO) && (char_data <= CH_NINE);
    assign digit_diff = char_data - CH_ZERO;
    assign digit      = digit_diff[3:0];
    assign keep       = accept && (char_data != CH_NL) && !comment_reg
                        && (char_data != CH_SPACE) && (char_data != CH_SLASH)
                        && (count_reg < CNT_W'(LINE_CHARS));
    assign line_push  = accept && (char_data == CH_NL)
                        && ((count_reg != '0) || overflow_reg);

    always_comb begin
        count_next          = count_reg;
        comment_next        = comment_reg;
        overflow_next       = overflow_reg;
        eq_found_next       = eq_found_reg;
        eq_pos_next         = eq_pos_reg;
        semi_any_found_next = semi_any_found_reg;
        semi_any_pos_next   = semi_any_pos_reg;
        semi_eq_found_next  = semi_eq_found_reg;
        semi_eq_pos_next    = semi_eq_pos_reg;
        second_digit_next   = second_digit_reg;
        all_digits_next     = all_digits_reg;
        value_next          = value_reg;
        if (accept) begin
            if (char_data == CH_NL) begin
                count_next          = '0;
                comment_next        = 1'b0;
                overflow_next       = 1'b0;
                eq_found_next       = 1'b0;
                semi_any_found_next = 1'b0;
                semi_eq_found_next  = 1'b0;
                second_digit_next   = 1'b0;
                all_digits_next     = 1'b1;
                value_next          = '0;
            end else if (comment_reg || char_data == CH_SPACE) begin
                comment_next = comment_reg;
            end else if (char_data == CH_SLASH) begin
                comment_next = 1'b1;
            end else if (count_reg < CNT_W'(LINE_CHARS)) begin
                count_next = count_reg + CNT_W'(1);
                if (!eq_found_reg && char_data == CH_EQ) begin
                    eq_found_next = 1'b1;
                    eq_pos_next   = idx;
                end
                if (!semi_any_found_reg && char_data == CH_SEMI) begin
                    semi_any_found_next = 1'b1;
                    semi_any_pos_next   = idx;
                end
                // once a '=' has been seen, only a ';' after it splits comp from jump
                if (eq_found_reg && !semi_eq_found_reg && char_data == CH_SEMI) begin
                    semi_eq_found_next = 1'b1;
                    semi_eq_pos_next   = idx;
                end
                if (count_reg != '0) begin
                    if (is_digit) begin
                        value_next = (value_reg << 3) + (value_reg << 1) + {12'h000, digit};
                    end else begin
                        all_digits_next = 1'b0;
                    end
                    if (count_reg == CNT_W'(1)) begin
                        second_digit_next = is_digit;
                    end
                end
            end else begin
                overflow_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg          <= '0;
            comment_reg        <= 1'b0;
            overflow_reg       <= 1'b0;
            eq_found_reg       <= 1'b0;
            eq_pos_reg         <= '0;
            semi_any_found_reg <= 1'b0;
            semi_any_pos_reg   <= '0;
            semi_eq_found_reg  <= 1'b0;
            semi_eq_pos_reg    <= '0;
            second_digit_reg   <= 1'b0;
            all_digits_reg     <= 1'b1;
            value_reg          <= '0;
        end else begin
            count_reg          <= count_next;
            comment_reg        <= comment_next;
            overflow_reg       <= overflow_next;
            eq_found_reg       <= eq_found_next;
            eq_pos_reg         <= eq_pos_next;
            semi_any_found_reg <= semi_any_found_next;
            semi_any_pos_reg   <= semi_any_pos_next;
            semi_eq_found_reg  <= semi_eq_found_next;
            semi_eq_pos_reg    <= semi_eq_pos_next;
            second_digit_reg   <= second_digit_next;
            all_digits_reg     <= all_digits_next;
            value_reg          <= value_next;
        end
    end

    // line store, written at the fill position, no reset
    always_ff @(posedge aclk) begin
        if (keep) begin
            text_reg[idx] <= char_data;
        end
    end

    always_comb begin
        for (int i = 0; i < LINE_CHARS; i++) begin
            line_out.text[i] = text_reg[i];
        end
        line_out.count          = count_reg;
        line_out.overflow       = overflow_reg;
        line_out.eq_found       = eq_found_reg;
        line_out.eq_pos         = eq_pos_reg;
        line_out.semi_any_found = semi_any_found_reg;
        line_out.semi_any_pos   = semi_any_pos_reg;
        line_out.semi_eq_found  = semi_eq_found_reg;
        line_out.semi_eq_pos    = semi_eq_pos_reg;
        line_out.second_digit   = second_digit_reg;
        line_out.all_digits     = all_digits_reg;
        line_out.addr_value     = value_reg;
    end

endmodule

// File: src/ale_queue.sv
// short queue of finished lines between front end and back end
module ale_queue import ale_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push,
    input  line_t push_data,
    output logic  full,
    output logic  pop_valid,
    input  logic  pop_ready,
    output line_t pop_data
);

    line_t             mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] fill_reg, fill_next;
    logic              do_push, do_pop;

    assign full      = (fill_reg == QCNT_W'(QUEUE_DEPTH));
    assign pop_valid = (fill_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop_valid && pop_ready;
    assign pop_data  = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                          : wr_ptr_reg + QPTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                          : rd_ptr_reg + QPTR_W'(1);
        end
        case ({do_push, do_pop})
            2'b10:   fill_next = fill_reg + QCNT_W'(1);
            2'b01:   fill_next = fill_reg - QCNT_W'(1);
            default: fill_next = fill_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: src/ale_back.sv
// back end: splits a line into its parts, looks up the mnemonics and builds the word
module ale_back import ale_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        line_valid,
    output logic        line_ready,
    input  line_t       line_in,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] out_word,
    output logic [2:0]  out_status
);

    function automatic seg_t extract(input logic [LINE_CHARS-1:0][7:0] text,
                                     input logic [CNT_W-1:0] start,
                                     input logic [CNT_W-1:0] len);
        seg_t       s;
        logic [7:0] b [3];
        logic [CNT_W:0] p;
        for (int k = 0; k < 3; k++) begin
            p    = {1'b0, start} + (CNT_W + 1)'(k);
            b[k] = (p < (CNT_W + 1)'(LINE_CHARS)) ? text[p[IDX_W-1:0]] : 8'h00;
        end
        s.too_long = (len > CNT_W'(3));
        s.len      = len[1:0];
        case (len[1:0])
            2'd0:    s.text = 24'h000000;
            2'd1:    s.text = {16'h0000, b[0]};
            2'd2:    s.text = {8'h00, b[0], b[1]};
            default: s.text = {b[0], b[1], b[2]};
        endcase
        return s;
    endfunction

    // {ok, code}
    function automatic logic [7:0] comp_code(input seg_t s);
        logic [7:0] r;
        unique case ({s.len, s.text})
            {2'd1, 24'("0")}:   r = {1'b1, 7'h2A};
            {2'd1, 24'("1")}:   r = {1'b1, 7'h3F};
            {2'd2, 24'("-1")}:  r = {1'b1, 7'h3A};
            {2'd1, 24'("D")}:   r = {1'b1, 7'h0C};
            {2'd1, 24'("A")}:   r = {1'b1, 7'h30};
            {2'd2, 24'("!D")}:  r = {1'b1, 7'h0D};
            {2'd2, 24'("!A")}:  r = {1'b1, 7'h31};
            {2'd2, 24'("-D")}:  r = {1'b1, 7'h0F};
            {2'd2, 24'("-A")}:  r = {1'b1, 7'h33};
            {2'd3, 24'("D+1")}: r = {1'b1, 7'h1F};
            {2'd3, 24'("A+1")}: r = {1'b1, 7'h37};
            {2'd3, 24'("D-1")}: r = {1'b1, 7'h0E};
            {2'd3, 24'("A-1")}: r = {1'b1, 7'h32};
            {2'd3, 24'("D+A")}: r = {1'b1, 7'h02};
            {2'd3, 24'("D-A")}: r = {1'b1, 7'h13};
            {2'd3, 24'("A-D")}: r = {1'b1, 7'h07};
            {2'd3, 24'("D&A")}: r = {1'b1, 7'h00};
            {2'd3, 24'("D|A")}: r = {1'b1, 7'h15};
            {2'd1, 24'("M")}:   r = {1'b1, 7'h70};
            {2'd2, 24'("!M")}:  r = {1'b1, 7'h71};
            {2'd2, 24'("-M")}:  r = {1'b1, 7'h73};
            {2'd3, 24'("M+1")}: r = {1'b1, 7'h77};
            {2'd3, 24'("M-1")}: r = {1'b1, 7'h72};
            {2'd3, 24'("D+M")}: r = {1'b1, 7'h42};
            {2'd3, 24'("D-M")}: r = {1'b1, 7'h53};
            {2'd3, 24'("M-D")}: r = {1'b1, 7'h47};
            {2'd3, 24'("D&M")}: r = {1'b1, 7'h40};
            {2'd3, 24'("D|M")}: r = {1'b1, 7'h55};
            default:            r = 8'h00;
        endcase
        return s.too_long ? 8'h00 : r;
    endfunction

    function automatic logic [3:0] dest_code(input seg_t s);
        logic [3:0] r;
        unique case ({s.len, s.text})
            {2'd0, 24'h000000}: r = 4'b1_000;
            {2'd1, 24'("M")}:   r = 4'b1_001;
            {2'd1, 24'("D")}:   r = 4'b1_010;
            {2'd2, 24'("MD")}:  r = 4'b1_011;
            {2'd1, 24'("A")}:   r = 4'b1_100;
            {2'd2, 24'("AM")}:  r = 4'b1_101;
            {2'd2, 24'("AD")}:  r = 4'b1_110;
            {2'd3, 24'("AMD")}: r = 4'b1_111;
            default:            r = 4'b0_000;
        endcase
        return s.too_long ? 4'b0_000 : r;
    endfunction

    function automatic logic [3:0] jump_code(input seg_t s);
        logic [3:0] r;
        unique case ({s.len, s.text})
            {2'd0, 24'h000000}: r = 4'b1_000;
            {2'd3, 24'("JGT")}: r = 4'b1_001;
            {2'd3, 24'("JEQ")}: r = 4'b1_010;
            {2'd3, 24'("JGE")}: r = 4'b1_011;
            {2'd3, 24'("JLT")}: r = 4'b1_100;
            {2'd3, 24'("JNE")}: r = 4'b1_101;
            {2'd3, 24'("JLE")}: r = 4'b1_110;
            {2'd3, 24'("JMP")}: r = 4'b1_111;
            default:            r = 4'b0_000;
        endcase
        return s.too_long ? 4'b0_000 : r;
    endfunction

    logic        split_valid_reg;
    split_t      split_reg, split_next;
    logic        out_valid_reg;
    logic [15:0] word_reg, word_next;
    logic [2:0]  status_reg, status_next;
    logic        out_free, split_free;

    logic [CNT_W-1:0] n, eq_at, cstart, semi, jstart;
    logic [7:0]       c_res;
    logic [3:0]       d_res, j_res;

    assign out_free   = !out_valid_reg || out_ready;
    assign split_free = !split_valid_reg || out_free;
    assign line_ready = split_free;

    // stage 1: locate dest, comp and jump, classify the line
    always_comb begin
        n      = line_in.count;
        eq_at  = line_in.eq_found ? CNT_W'(line_in.eq_pos) : '0;
        cstart = line_in.eq_found ? CNT_W'(line_in.eq_pos) + CNT_W'(1) : '0;
        if (line_in.eq_found) begin
            semi = line_in.semi_eq_found ? CNT_W'(line_in.semi_eq_pos) : n;
        end else begin
            semi = line_in.semi_any_found ? CNT_W'(line_in.semi_any_pos) : n;
        end
        jstart = (semi < n) ? semi + CNT_W'(1) : n;

        split_next.addr_value = line_in.addr_value;
        split_next.dest       = extract(line_in.text, '0, eq_at);
        split_next.comp       = extract(line_in.text, cstart, semi - cstart);
        split_next.jump       = extract(line_in.text, jstart, n - jstart);
        if (line_in.overflow) begin
            split_next.kind = ST_LONG;
        end else if (line_in.text[0] == CH_LPAREN) begin
            split_next.kind = ST_SYMBOL;
        end else if (line_in.text[0] == CH_AT) begin
            if (n < CNT_W'(2) || !line_in.second_digit) begin
                split_next.kind = ST_SYMBOL;
            end else if (!line_in.all_digits) begin
                split_next.kind = ST_UNKNOWN;
            end else begin
                split_next.kind = ST_ADDR;
            end
        end else begin
            split_next.kind = ST_COMP;
        end
    end

    // stage 2: table lookups and word assembly
    always_comb begin
        c_res = comp_code(split_reg.comp);
        d_res = dest_code(split_reg.dest);
        j_res = jump_code(split_reg.jump);
        word_next   = 16'h0000;
        status_next = split_reg.kind;
        if (split_reg.kind == ST_COMP) begin
            if (c_res[7] && d_res[3] && j_res[3]) begin
                word_next = {3'b111, c_res[6:0], d_res[2:0], j_res[2:0]};
            end else begin
                status_next = ST_UNKNOWN;
            end
        end else if (split_reg.kind == ST_ADDR) begin
            word_next = split_reg.addr_value;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            split_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end else begin
            if (split_free) begin
                split_valid_reg <= line_valid;
            end
            if (out_free) begin
                out_valid_reg <= split_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (split_free && line_valid) begin
            split_reg <= split_next;
        end
        if (out_free && split_valid_reg) begin
            word_reg   <= word_next;
            status_reg <= status_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_word   = word_reg;
    assign out_status = status_reg;

endmodule

// File: src/assembly_line_encoder.sv
// top level of the assembly line encoder: front end, line queue and back end
//
// usage
//   s_ channel: one source character per transfer, 10 ends a line; spaces are
//   dropped and '/' turns the rest of the line into a comment
//   m_ channel: one transfer per non-empty line, carrying the 16-bit machine
//   word in m_tdata and the status code in m_tuser (0 address, 1 compute,
//   2 unknown mnemonic, 3 symbol or label, 4 line too long; word 0 unless
//   status is 0 or 1)
// throughput: one character per cycle while the line queue is not full; the
//   back end takes one line per cycle while its output is not stalled
// path: after the transfer of its newline a line passes the queue write,
//   the split stage and the output register, which then holds its result
// stall: while m_tready is low the result is held; the two-entry line queue
//   keeps taking characters until it is full, then s_tready drops
// reset: aresetn, synchronous and active low, empties the queue and the
//   pipeline and starts a fresh line; the line store itself is not cleared
module assembly_line_encoder import ale_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    // input channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] character
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] machine_word
    output logic [2:0]  m_tuser    // [2:0] status
);

    // front end to queue
    logic  line_push;
    line_t line_push_data;
    logic  queue_full;

    // queue to back end
    logic  line_valid;
    logic  line_ready;
    line_t line_data;

    // gathers a line a character at a time
    ale_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .char_valid (s_tvalid),
        .char_data  (s_tdata),
        .queue_full (queue_full),
        .char_ready (s_tready),
        .line_push  (line_push),
        .line_out   (line_push_data)
    );

    // finished lines wait here so a stalled receiver does not stop the input at once
    ale_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (line_push),
        .push_data (line_push_data),
        .full      (queue_full),
        .pop_valid (line_valid),
        .pop_ready (line_ready),
        .pop_data  (line_data)
    );

    // encodes one line per cycle into the output register while the output is not stalled
    ale_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .line_valid (line_valid),
        .line_ready (line_ready),
        .line_in    (line_data),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_word   (m_tdata),
        .out_status (m_tuser)
    );

endmodule

// File: src/ale_checker.sv
// port checker for the assembly line encoder and its bind
module ale_checker import ale_pkg::*; (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic [2:0]  m_tuser
);

    // a stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // nothing leaves straight after reset, and the input side is open
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid && s_tready)
        else $error("result valid or input blocked after reset");

    // flagged lines carry a zero word
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == ST_UNKNOWN || m_tuser == ST_SYMBOL || m_tuser == ST_LONG)
        |-> m_tdata == 16'h0000)
        else $error("flagged line with non-zero word");

    // compute words open with the three ones
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == ST_COMP |-> m_tdata[15:13] == 3'b111)
        else $error("compute word without prefix");

    // status stays within its codes
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == ST_ADDR || m_tuser == ST_COMP || m_tuser == ST_UNKNOWN
                      || m_tuser == ST_SYMBOL || m_tuser == ST_LONG))
        else $error("status code out of range");

endmodule

bind assembly_line_encoder ale_checker u_ale_checker (.*);

// File: test/ale_line_checker.sv
// line checker for the assembly line encoder: predicts each machine word and compares it
module ale_line_checker import ale_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,
    input  logic [2:0]  m_tuser,
    output int          fail_count,
    output int          words_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [15:0] word;
        logic [2:0]  status;
    } word_rec_t;

    typedef enum int {PART_DEST, PART_COMP, PART_JUMP} part_t;

    // mnemonic tables; dest and jump codes are the table index
    string dest_names [8] = '{"", "M", "D", "MD", "A", "AM", "AD", "AMD"};
    string jump_names [8] = '{"", "JGT", "JEQ", "JGE", "JLT", "JNE", "JLE", "JMP"};
    string comp_names [28] = '{
        "0", "1", "-1", "D", "A", "!D", "!A", "-D", "-A",
        "D+1", "A+1", "D-1", "A-1", "D+A", "D-A", "A-D", "D&A", "D|A",
        "M", "!M", "-M", "M+1", "M-1", "D+M", "D-M", "M-D", "D&M", "D|M"};
    logic [6:0] comp_codes [28] = '{
        7'h2A, 7'h3F, 7'h3A, 7'h0C, 7'h30, 7'h0D, 7'h31, 7'h0F, 7'h33,
        7'h1F, 7'h37, 7'h0E, 7'h32, 7'h02, 7'h13, 7'h07, 7'h00, 7'h15,
        7'h70, 7'h71, 7'h73, 7'h77, 7'h72, 7'h42, 7'h53, 7'h47, 7'h40, 7'h55};

    logic [7:0] held [LINE_CHARS];
    int         held_n    = 0;
    bit         in_note   = 1'b0;
    bit         held_over = 1'b0;
    word_rec_t  words_due [$];
    word_rec_t  due;
    int         fails = 0;

    function automatic bit same_text(string nm, int lo, int hi);
        if (nm.len() != hi - lo) return 1'b0;
        for (int k = 0; k < nm.len(); k++) begin
            if (held[lo + k] != 8'(nm[k])) return 1'b0;
        end
        return 1'b1;
    endfunction

    // code of the held segment [lo, hi) in one table, -1 when absent
    function automatic int part_code(part_t part, int lo, int hi);
        int    n_entries;
        string nm;
        n_entries = (part == PART_COMP) ? $size(comp_names) : $size(dest_names);
        for (int i = 0; i < n_entries; i++) begin
            case (part)
                PART_DEST: nm = dest_names[i];
                PART_COMP: nm = comp_names[i];
                default:   nm = jump_names[i];
            endcase
            if (same_text(nm, lo, hi)) return (part == PART_COMP) ? int'(comp_codes[i]) : i;
        end
        return -1;
    endfunction

    function automatic word_rec_t encode_line_word();
        word_rec_t   r;
        logic [15:0] v;
        int          eq, semi, cstart, d, c, j;
        r.word   = 16'd0;
        r.status = ST_UNKNOWN;
        if (held_over) begin
            r.status = ST_LONG;
            return r;
        end
        if (held[0] == CH_LPAREN) begin
            r.status = ST_SYMBOL;
            return r;
        end
        if (held[0] == CH_AT) begin
            if (held_n < 2 || held[1] < CH_ZERO || held[1] > CH_NINE) begin
                r.status = ST_SYMBOL;
                return r;
            end
            v = 16'd0;
            for (int i = 1; i < held_n; i++) begin
                if (held[i] < CH_ZERO || held[i] > CH_NINE) return r;
                v = v * 16'd10 + 16'(held[i] - CH_ZERO);
            end
            r.word   = v;
            r.status = ST_ADDR;
            return r;
        end
        // first '=' splits off dest, first ';' after it splits off jump
        eq = held_n;
        for (int i = 0; i < held_n; i++) begin
            if (held[i] == CH_EQ) begin
                eq = i;
                break;
            end
        end
        cstart = (eq < held_n) ? eq + 1 : 0;
        semi   = held_n;
        for (int i = cstart; i < held_n; i++) begin
            if (held[i] == CH_SEMI) begin
                semi = i;
                break;
            end
        end
        d = part_code(PART_DEST, 0, (eq < held_n) ? eq : 0);
        c = part_code(PART_COMP, cstart, semi);
        j = part_code(PART_JUMP, (semi < held_n) ? semi + 1 : held_n, held_n);
        if (d < 0 || c < 0 || j < 0) return r;
        r.word   = {3'b111, 7'(c), 3'(d), 3'(j)};
        r.status = ST_COMP;
        return r;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            held_n    = 0;
            in_note   = 1'b0;
            held_over = 1'b0;
            words_due.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (words_due.size() == 0) begin
                    fails++;
                    $display("%0t: unexpected result word %h status %0d",
                             $time, m_tdata, m_tuser);
                end else begin
                    due = words_due.pop_front();
                    if (m_tdata !== due.word || m_tuser !== due.status) begin
                        fails++;
                        $display("%0t: mismatch, expected word %h status %0d, got word %h status %0d",
                                 $time, due.word, due.status, m_tdata, m_tuser);
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                if (s_tdata == CH_NL) begin
                    if (held_n > 0 || held_over) words_due.push_back(encode_line_word());
                    held_n    = 0;
                    in_note   = 1'b0;
                    held_over = 1'b0;
                end else if (!in_note && s_tdata != CH_SPACE) begin
                    if (s_tdata == CH_SLASH) in_note = 1'b1;
                    else if (held_n < LINE_CHARS) held[held_n++] = s_tdata;
                    else held_over = 1'b1;
                end
            end
        end
        fail_count    <= fails;
        words_pending <= words_due.size();
    end

endmodule

// File: test/tb_assembly_line_encoder.sv
// testbench top for the assembly line encoder: source text stimulus, back-pressure and verdict
module tb_assembly_line_encoder;
    timeunit 1ns;
    timeprecision 1ps;
    import ale_pkg::*;

    // characters used only by the stimulus
    localparam logic [7:0] CH_TAB    = 8'd9;
    localparam logic [7:0] CH_CR     = 8'd13;
    localparam logic [7:0] CH_RPAREN = 8'h29;

    // random part length in characters, and the idle limit of the watchdog;
    // the limit leaves a wide margin over any sender gap or receiver stall
    localparam int RANDOM_CHARS = 330;
    localparam int IDLE_LIMIT   = 5000;

    typedef enum int {RX_OPEN, RX_COIN, RX_TIGHT, RX_PULSE} rx_mode_t;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'd0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic [2:0]  m_tuser;
    int          fail_count;
    int          words_pending;

    // mnemonic spellings used to build well-formed lines
    string dest_txt [8] = '{"", "M", "D", "MD", "A", "AM", "AD", "AMD"};
    string jump_txt [8] = '{"", "JGT", "JEQ", "JGE", "JLT", "JNE", "JLE", "JMP"};
    string comp_txt [28] = '{
        "0", "1", "-1", "D", "A", "!D", "!A", "-D", "-A",
        "D+1", "A+1", "D-1", "A-1", "D+A", "D-A", "A-D", "D&A", "D|A",
        "M", "!M", "-M", "M+1", "M-1", "D+M", "D-M", "M-D", "D&M", "D|M"};

    logic [7:0] line_bytes [$];   // the line being built, newline not included
    int         burst_left  = 0;  // transfers left in the current sender burst
    int         chars_sent  = 0;
    int         directed_chars;
    int         idle_cycles = 0;
    rx_mode_t   rx_mode     = RX_OPEN;
    int         rx_left     = 0;

    assembly_line_encoder u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    ale_line_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .fail_count    (fail_count),
        .words_pending (words_pending)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // receiver: picks a new stall pattern whenever the run of the last one ends,
    // so results are held back in every phase of the pipeline, with open
    // stretches in between
    always @(negedge aclk) begin
        if (rx_left == 0) begin
            rx_mode = rx_mode_t'($urandom_range(3));
            rx_left = $urandom_range(10, 80);
        end
        rx_left--;
        case (rx_mode)
            RX_OPEN:  m_tready <= 1'b1;
            RX_COIN:  m_tready <= 1'($urandom_range(1));
            RX_TIGHT: m_tready <= ($urandom_range(3) == 0);
            default:  m_tready <= ((rx_left % 8) < 3);
        endcase
    end

    // watchdog: cycles in which neither channel completes a transfer
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // one character transfer; called and left at a falling edge. a burst
    // that has run out first drops tvalid for a gap before the next character
    task automatic push_char(input logic [7:0] c);
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge aclk);
            burst_left = ($urandom_range(3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        burst_left--;
        chars_sent++;
        @(negedge aclk);
    endtask

    task automatic send_line();
        foreach (line_bytes[k]) push_char(line_bytes[k]);
        push_char(CH_NL);
        line_bytes.delete();
    endtask

    // spaced text gets stray spaces, which the block must drop
    task automatic add_str(input string txt, input bit spaced);
        for (int k = 0; k < txt.len(); k++) begin
            if (spaced && $urandom_range(7) == 0) line_bytes.push_back(CH_SPACE);
            line_bytes.push_back(8'(txt[k]));
        end
    endtask

    task automatic send_text(input string txt);
        add_str(txt, 1'b0);
        send_line();
    endtask

    // hold the sender until the checker has seen every expected word
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (words_pending != 0);
    endtask

    function automatic logic [7:0] noise_byte();
        logic [7:0] b;
        b = 8'($urandom_range(255));
        return (b == CH_NL) ? CH_SPACE : b;
    endfunction

    // printable, kept by the block: no space and no slash
    function automatic logic [7:0] text_char();
        logic [7:0] b;
        b = 8'($urandom_range(33, 126));
        return (b == CH_SLASH) ? 8'h58 : b;
    endfunction

    task automatic add_note();
        line_bytes.push_back(CH_SLASH);
        if ($urandom_range(1)) line_bytes.push_back(CH_SLASH);
        repeat ($urandom_range(6)) line_bytes.push_back(noise_byte());
    endtask

    // dest=comp;jump with dest and jump each optional
    task automatic add_compute();
        int d, j;
        d = $urandom_range(7);
        j = $urandom_range(7);
        if (d != 0) add_str({dest_txt[d], "="}, 1'b1);
        add_str(comp_txt[$urandom_range(27)], 1'b1);
        if (j != 0) add_str({";", jump_txt[j]}, 1'b1);
    endtask

    // mostly well-formed lines with random content; the rest symbols,
    // broken instructions, overlong lines and raw byte noise
    task automatic make_random_line();
        int pick, n;
        pick = $urandom_range(99);
        if (pick < 32) begin
            add_compute();
            if ($urandom_range(3) == 0) add_note();
        end else if (pick < 52) begin
            add_str("@", 1'b1);
            n = ($urandom_range(7) == 0) ? $urandom_range(6, 17) : $urandom_range(1, 5);
            repeat (n) line_bytes.push_back(8'(CH_ZERO + $urandom_range(9)));
            if ($urandom_range(3) == 0) add_note();
        end else if (pick < 58) begin
            // blank, spaces only or a note alone: no result
            repeat ($urandom_range(3)) line_bytes.push_back(CH_SPACE);
            if ($urandom_range(1)) add_note();
        end else if (pick < 66) begin
            case ($urandom_range(3))
                0: begin
                    line_bytes.push_back(CH_AT);
                    repeat ($urandom_range(1, 6)) line_bytes.push_back(8'($urandom_range(65, 90)));
                end
                1: begin
                    line_bytes.push_back(CH_LPAREN);
                    repeat ($urandom_range(1, 8)) line_bytes.push_back(text_char());
                    line_bytes.push_back(CH_RPAREN);
                end
                2: line_bytes.push_back(CH_AT);
                default: begin
                    line_bytes.push_back(CH_AT);
                    repeat ($urandom_range(1, 4)) line_bytes.push_back(8'(CH_ZERO + $urandom_range(9)));
                    line_bytes.push_back(text_char());
                end
            endcase
        end else if (pick < 80) begin
            // broken instruction: one byte replaced, or a stray separator
            add_compute();
            n = $urandom_range(line_bytes.size() - 1);
            case ($urandom_range(2))
                0: line_bytes[n] = text_char();
                1: line_bytes.insert(n, CH_EQ);
                default: line_bytes.insert(n, CH_SEMI);
            endcase
        end else if (pick < 88) begin
            repeat ($urandom_range(14, 20)) line_bytes.push_back(text_char());
        end else begin
            repeat ($urandom_range(1, 8)) line_bytes.push_back(noise_byte());
        end
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed lines: address extremes and wrap, full-width compute,
        // empty and note-only lines, symbols and labels, malformed constants
        // and mnemonics, the store exactly full and one past it, control and
        // extreme bytes
        send_text("@0");
        send_text("@000000000065535");
        send_text("@65536");
        send_text("AMD=D|M;JMP");
        send_text("0;JGE");
        send_text("M=M+1");
        send_text("");
        send_text("   // only a note");
        send_text("@");
        send_text("@LOOP");
        send_text("(LOOP)");
        send_text("@12a");
        send_text("D=Q");
        send_text("=D");
        send_text("D=");
        send_text("D=A=M");
        send_text("0;JMP;JMP");
        send_text("D;");
        send_text("ABCDEFGHIJKLMNOPQ");
        send_text("D = M // trailing note");
        add_str("D=", 1'b0);
        line_bytes.push_back(CH_TAB);
        add_str("M", 1'b0);
        line_bytes.push_back(CH_CR);
        send_line();
        line_bytes.push_back(8'h00);
        line_bytes.push_back(8'hFF);
        send_line();
        directed_chars = chars_sent;

        // let the pipeline run dry once before the random part
        drain_results();

        while (chars_sent - directed_chars < RANDOM_CHARS) begin
            make_random_line();
            send_line();
            if ($urandom_range(40) == 0) drain_results();
        end

        drain_results();
        repeat (4) @(negedge aclk);
        if (fail_count == 0 && words_pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
